@@ design/alm_pkg.sv @@
// shared types and constants of the alarm table scheduler
package alm_pkg;

    localparam int ALARM_SLOTS = 8;
    localparam int IDX_W       = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam int EVENT_W     = 8;
    localparam int DELAY_W     = 31;
    localparam int AUX_W       = 32;
    localparam int TIME_W      = 64;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ALARM_SLOTS - 1);

    // function codes of an input item
    localparam logic FUNC_ACTIVATE = 1'b0;
    localparam logic FUNC_TICK     = 1'b1;

    // result kinds
    localparam logic KIND_FIRED    = 1'b0;
    localparam logic KIND_OVERFLOW = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // contents of one alarm slot
    typedef struct packed {
        logic [EVENT_W-1:0] event_id;
        logic [AUX_W-1:0]   aux;
        logic [DELAY_W-1:0] delay;
        logic               periodic;
        logic [TIME_W-1:0]  start;
    } t_slot;

    // slot table update command
    typedef struct packed {
        logic             fill;
        logic             rearm;
        logic             clear;
        logic [IDX_W-1:0] addr;
    } t_store_cmd;

    // result of the shared compare unit
    typedef struct packed {
        logic ev_match;
        logic due;
    } t_cmp_res;

endpackage

@@ design/alm_store.sv @@
// alarm slot table: slot memories with registered read and per-slot valid flags
module alm_store (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  alm_pkg::t_store_cmd                i_cmd,
    input  alm_pkg::t_slot                     i_wr_data,
    input  logic [alm_pkg::IDX_W-1:0]          i_rd_addr,
    output alm_pkg::t_slot                     o_rd_data,
    output logic [alm_pkg::ALARM_SLOTS-1:0]    o_valid_vec
);

    logic [alm_pkg::EVENT_W-1:0] r_mem_event    [alm_pkg::ALARM_SLOTS];
    logic [alm_pkg::AUX_W-1:0]   r_mem_aux      [alm_pkg::ALARM_SLOTS];
    logic [alm_pkg::DELAY_W-1:0] r_mem_delay    [alm_pkg::ALARM_SLOTS];
    logic                        r_mem_periodic [alm_pkg::ALARM_SLOTS];
    logic [alm_pkg::TIME_W-1:0]  r_mem_start    [alm_pkg::ALARM_SLOTS];
    alm_pkg::t_slot              r_rd;
    logic [alm_pkg::ALARM_SLOTS-1:0] r_valid;

    // slot memory writes and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill) begin
            r_mem_event[i_cmd.addr]    <= i_wr_data.event_id;
            r_mem_aux[i_cmd.addr]      <= i_wr_data.aux;
            r_mem_delay[i_cmd.addr]    <= i_wr_data.delay;
            r_mem_periodic[i_cmd.addr] <= i_wr_data.periodic;
        end
        if (i_cmd.fill || i_cmd.rearm) begin
            r_mem_start[i_cmd.addr] <= i_wr_data.start;
        end
        r_rd.event_id <= r_mem_event[i_rd_addr];
        r_rd.aux      <= r_mem_aux[i_rd_addr];
        r_rd.delay    <= r_mem_delay[i_rd_addr];
        r_rd.periodic <= r_mem_periodic[i_rd_addr];
        r_rd.start    <= r_mem_start[i_rd_addr];
    end

    // valid flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_cmd.fill) begin
                r_valid[i_cmd.addr] <= 1'b1;
            end else if (i_cmd.clear) begin
                r_valid[i_cmd.addr] <= 1'b0;
            end
        end
    end

    assign o_rd_data   = r_rd;
    assign o_valid_vec = r_valid;

endmodule

@@ design/alm_cmp.sv @@
// shared compare unit: elapsed time against delay, event id match
module alm_cmp (
    input  alm_pkg::t_slot              i_slot,
    input  logic [alm_pkg::EVENT_W-1:0] i_event_id,
    input  logic [alm_pkg::TIME_W-1:0]  i_now,
    output alm_pkg::t_cmp_res           o_res
);

    logic [alm_pkg::TIME_W-1:0] elapsed;

    // wrapping elapsed time, then one wide compare
    always_comb begin
        elapsed        = i_now - i_slot.start;
        o_res.due      = (elapsed >= alm_pkg::TIME_W'(i_slot.delay));
        o_res.ev_match = (i_slot.event_id == i_event_id);
    end

endmodule

@@ design/alm_ctrl.sv @@
// scan sequencer: one slot per cycle unless the output stalls, builds result items
module alm_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_func,
    input  logic [alm_pkg::EVENT_W-1:0]      i_event_id,
    input  logic [alm_pkg::DELAY_W-1:0]      i_delay,
    input  logic                             i_periodic,
    input  logic [alm_pkg::AUX_W-1:0]        i_aux_data,
    input  logic [alm_pkg::TIME_W-1:0]       i_now,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_kind,
    output logic [alm_pkg::EVENT_W-1:0]      o_out_event,
    output logic [alm_pkg::AUX_W-1:0]        o_out_aux,
    output logic                             o_last,
    output logic                             o_none_active,
    output alm_pkg::t_store_cmd              o_cmd,
    output alm_pkg::t_slot                   o_wr_data,
    output logic [alm_pkg::IDX_W-1:0]        o_rd_addr,
    input  alm_pkg::t_slot                   i_rd_data,
    input  logic [alm_pkg::ALARM_SLOTS-1:0]  i_valid_vec,
    output logic [alm_pkg::EVENT_W-1:0]      o_cmp_event,
    output logic [alm_pkg::TIME_W-1:0]       o_cmp_now,
    input  alm_pkg::t_cmp_res                i_cmp
);

    alm_pkg::t_state r_state, n_state;

    logic [alm_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic                        r_func, n_func;
    logic [alm_pkg::EVENT_W-1:0] r_ev, n_ev;
    logic [alm_pkg::DELAY_W-1:0] r_dly, n_dly;
    logic                        r_per, n_per;
    logic [alm_pkg::AUX_W-1:0]   r_aux, n_aux;
    logic [alm_pkg::TIME_W-1:0]  r_now, n_now;
    logic                        r_have_free, n_have_free;
    logic [alm_pkg::IDX_W-1:0]   r_free_idx, n_free_idx;

    // pending result, held until it is known whether it is the last one
    logic                        r_p_valid, n_p_valid;
    logic                        r_p_kind, n_p_kind;
    logic [alm_pkg::EVENT_W-1:0] r_p_event, n_p_event;
    logic [alm_pkg::AUX_W-1:0]   r_p_aux, n_p_aux;
    logic                        r_p_none, n_p_none;

    // output register
    logic                        r_o_valid, n_o_valid;
    logic                        r_o_kind, n_o_kind;
    logic [alm_pkg::EVENT_W-1:0] r_o_event, n_o_event;
    logic [alm_pkg::AUX_W-1:0]   r_o_aux, n_o_aux;
    logic                        r_o_last, n_o_last;
    logic                        r_o_none, n_o_none;

    logic                             accept;
    logic                             is_last;
    logic                             out_free;
    logic                             slot_v;
    logic                             fire;
    logic                             step_ok;
    logic                             act_match;
    logic                             cancel;
    logic                             have_free_now;
    logic [alm_pkg::IDX_W-1:0]        free_addr;
    logic [alm_pkg::ALARM_SLOTS-1:0]  v_after;

    // scan conditions
    always_comb begin
        accept        = i_in_valid && (r_state == alm_pkg::ST_IDLE);
        is_last       = (r_idx == alm_pkg::IDX_LAST);
        out_free      = !r_o_valid || !i_out_stall;
        slot_v        = i_valid_vec[r_idx];
        fire          = (r_func == alm_pkg::FUNC_TICK) && slot_v && i_cmp.due;
        step_ok       = !fire || !r_p_valid || out_free;
        act_match     = (r_func == alm_pkg::FUNC_ACTIVATE) && slot_v && i_cmp.ev_match;
        cancel        = (r_dly == '0) && !r_per;
        have_free_now = r_have_free || !slot_v;
        free_addr     = r_have_free ? r_free_idx : r_idx;
        v_after       = i_valid_vec;
        if (!i_rd_data.periodic) begin
            v_after[r_idx] = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            alm_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = alm_pkg::ST_SCAN;
                end
            end
            alm_pkg::ST_SCAN: begin
                if (r_func == alm_pkg::FUNC_ACTIVATE) begin
                    if (act_match) begin
                        n_state = alm_pkg::ST_IDLE;
                    end else if (is_last) begin
                        n_state = (cancel || have_free_now) ? alm_pkg::ST_IDLE
                                                            : alm_pkg::ST_FLUSH;
                    end
                end else if (step_ok && is_last) begin
                    n_state = (fire || r_p_valid) ? alm_pkg::ST_FLUSH : alm_pkg::ST_IDLE;
                end
            end
            alm_pkg::ST_FLUSH: begin
                if (out_free) begin
                    n_state = alm_pkg::ST_IDLE;
                end
            end
            default: n_state = alm_pkg::ST_IDLE;
        endcase
    end

    // datapath, table commands and results
    always_comb begin
        n_idx       = r_idx;
        n_func      = r_func;
        n_ev        = r_ev;
        n_dly       = r_dly;
        n_per       = r_per;
        n_aux       = r_aux;
        n_now       = r_now;
        n_have_free = r_have_free;
        n_free_idx  = r_free_idx;
        n_p_valid   = r_p_valid;
        n_p_kind    = r_p_kind;
        n_p_event   = r_p_event;
        n_p_aux     = r_p_aux;
        n_p_none    = r_p_none;
        n_o_valid   = r_o_valid;
        n_o_kind    = r_o_kind;
        n_o_event   = r_o_event;
        n_o_aux     = r_o_aux;
        n_o_last    = r_o_last;
        n_o_none    = r_o_none;
        o_cmd       = '0;
        o_rd_addr   = '0;

        // result taken downstream
        if (r_o_valid && !i_out_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            alm_pkg::ST_IDLE: begin
                if (accept) begin
                    n_func      = i_func;
                    n_ev        = i_event_id;
                    n_dly       = i_delay;
                    n_per       = i_periodic;
                    n_aux       = i_aux_data;
                    n_now       = i_now;
                    n_idx       = '0;
                    n_have_free = 1'b0;
                    n_p_valid   = 1'b0;
                end
            end
            alm_pkg::ST_SCAN: begin
                o_rd_addr = r_idx;
                if (r_func == alm_pkg::FUNC_ACTIVATE) begin
                    // look for the same event id, remember the first free slot
                    if (act_match) begin
                        o_cmd.addr  = r_idx;
                        o_cmd.clear = cancel;
                        o_cmd.fill  = !cancel;
                    end else begin
                        if (!slot_v && !r_have_free) begin
                            n_have_free = 1'b1;
                            n_free_idx  = r_idx;
                        end
                        if (is_last) begin
                            if (!cancel && have_free_now) begin
                                o_cmd.addr = free_addr;
                                o_cmd.fill = 1'b1;
                            end else if (!cancel) begin
                                // table full
                                n_p_valid = 1'b1;
                                n_p_kind  = alm_pkg::KIND_OVERFLOW;
                                n_p_event = '0;
                                n_p_aux   = '0;
                                n_p_none  = 1'b0;
                            end
                        end else begin
                            n_idx     = r_idx + 1'b1;
                            o_rd_addr = r_idx + 1'b1;
                        end
                    end
                end else if (step_ok) begin
                    // tick: fire due alarms, earlier pending result is not last
                    if (fire) begin
                        if (r_p_valid) begin
                            n_o_valid = 1'b1;
                            n_o_kind  = r_p_kind;
                            n_o_event = r_p_event;
                            n_o_aux   = r_p_aux;
                            n_o_last  = 1'b0;
                            n_o_none  = r_p_none;
                        end
                        n_p_valid   = 1'b1;
                        n_p_kind    = alm_pkg::KIND_FIRED;
                        n_p_event   = i_rd_data.event_id;
                        n_p_aux     = i_rd_data.aux;
                        n_p_none    = ~|v_after;
                        o_cmd.addr  = r_idx;
                        o_cmd.rearm = i_rd_data.periodic;
                        o_cmd.clear = !i_rd_data.periodic;
                    end
                    if (!is_last) begin
                        n_idx     = r_idx + 1'b1;
                        o_rd_addr = r_idx + 1'b1;
                    end
                end
            end
            alm_pkg::ST_FLUSH: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = r_p_kind;
                    n_o_event = r_p_event;
                    n_o_aux   = r_p_aux;
                    n_o_last  = 1'b1;
                    n_o_none  = r_p_none;
                    n_p_valid = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= alm_pkg::ST_IDLE;
            r_have_free <= 1'b0;
            r_p_valid   <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_have_free <= n_have_free;
            r_p_valid   <= n_p_valid;
            r_o_valid   <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_func     <= n_func;
        r_ev       <= n_ev;
        r_dly      <= n_dly;
        r_per      <= n_per;
        r_aux      <= n_aux;
        r_now      <= n_now;
        r_free_idx <= n_free_idx;
        r_p_kind   <= n_p_kind;
        r_p_event  <= n_p_event;
        r_p_aux    <= n_p_aux;
        r_p_none   <= n_p_none;
        r_o_kind   <= n_o_kind;
        r_o_event  <= n_o_event;
        r_o_aux    <= n_o_aux;
        r_o_last   <= n_o_last;
        r_o_none   <= n_o_none;
    end

    assign o_in_stall         = (r_state != alm_pkg::ST_IDLE);
    assign o_out_valid        = r_o_valid;
    assign o_kind             = r_o_kind;
    assign o_out_event        = r_o_event;
    assign o_out_aux          = r_o_aux;
    assign o_last             = r_o_last;
    assign o_none_active      = r_o_none;
    assign o_wr_data.event_id = r_ev;
    assign o_wr_data.aux      = r_aux;
    assign o_wr_data.delay    = r_dly;
    assign o_wr_data.periodic = r_per;
    assign o_wr_data.start    = r_now;
    assign o_cmp_event        = r_ev;
    assign o_cmp_now          = r_now;

endmodule

@@ design/alarm_table_scheduler.sv @@
// top level of the alarm table scheduler
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------------
//  in       | input     | i_in_valid / o_in_stall    | func, event_id, delay, periodic,
//           |           |                            | aux_data, now
//  out      | output    | o_out_valid / i_out_stall  | kind, out_event, out_aux, last,
//           |           |                            | none_active
//
// an item is accepted in idle and then visits the slots in turn: the scan walks the
// slot table through its single read port and the one shared compare unit, so a tick
// visits every slot; its last result, or an activate's overflow, goes out from flush.
// an activate stops at the slot holding its event id.
// reset clears the valid flags at once; no clearing pass is needed.
// a stall on the output holds the scan at the next due slot; a finished result may
// wait in the output register while the next item is accepted.
module alarm_table_scheduler (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_func,
    input  logic [alm_pkg::EVENT_W-1:0] i_event_id,
    input  logic [alm_pkg::DELAY_W-1:0] i_delay,
    input  logic                        i_periodic,
    input  logic [alm_pkg::AUX_W-1:0]   i_aux_data,
    input  logic [alm_pkg::TIME_W-1:0]  i_now,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_kind,
    output logic [alm_pkg::EVENT_W-1:0] o_out_event,
    output logic [alm_pkg::AUX_W-1:0]   o_out_aux,
    output logic                        o_last,
    output logic                        o_none_active
);

    alm_pkg::t_store_cmd                store_cmd;
    alm_pkg::t_slot                     wr_data;
    alm_pkg::t_slot                     rd_data;
    logic [alm_pkg::IDX_W-1:0]          rd_addr;
    logic [alm_pkg::ALARM_SLOTS-1:0]    valid_vec;
    logic [alm_pkg::EVENT_W-1:0]        cmp_event;
    logic [alm_pkg::TIME_W-1:0]         cmp_now;
    alm_pkg::t_cmp_res                  cmp_res;

    // slot table
    alm_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (store_cmd),
        .i_wr_data   (wr_data),
        .i_rd_addr   (rd_addr),
        .o_rd_data   (rd_data),
        .o_valid_vec (valid_vec)
    );

    // shared compare unit
    alm_cmp u_cmp (
        .i_slot     (rd_data),
        .i_event_id (cmp_event),
        .i_now      (cmp_now),
        .o_res      (cmp_res)
    );

    // scan sequencer
    alm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_event_id    (i_event_id),
        .i_delay       (i_delay),
        .i_periodic    (i_periodic),
        .i_aux_data    (i_aux_data),
        .i_now         (i_now),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_out_event   (o_out_event),
        .o_out_aux     (o_out_aux),
        .o_last        (o_last),
        .o_none_active (o_none_active),
        .o_cmd         (store_cmd),
        .o_wr_data     (wr_data),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .i_valid_vec   (valid_vec),
        .o_cmp_event   (cmp_event),
        .o_cmp_now     (cmp_now),
        .i_cmp         (cmp_res)
    );

endmodule
